// File: src/aabbco_pkg.sv
// ----------------------------------------------------------------------------
// aabbco_pkg
// Shared types and constants for the box / circle overlap test.
// ----------------------------------------------------------------------------
package aabbco_pkg;

    // default coordinate width, signed fixed point
    localparam int COORD_BITS_DEF = 16;

    // shape pairing, coded as {kind_a, kind_b} with 0 box and 1 circle
    typedef enum logic [1:0] {
        PAIR_BOX_BOX   = 2'b00,
        PAIR_BOX_CIRC  = 2'b01,
        PAIR_CIRC_BOX  = 2'b10,
        PAIR_CIRC_CIRC = 2'b11
    } pair_kind_t;

endpackage

// File: src/aabb_circle_overlap_test.sv
// Pairwise overlap test for axis-aligned boxes and circles in signed fixed
// point (Q11.4 at the default width). Each input transfer carries two shapes;
// each gives exactly one output transfer with a single overlap flag, and
// touching shapes count as overlapping. All squares and sums are exact. A pair
// enters the input register, is evaluated in one combinational pass (three
// parallel squarers and one compare) and lands in the result register. One
// pair is accepted every cycle as long as the output side keeps taking results.
// ----------------------------------------------------------------------------
// aabb_circle_overlap_test
// Top level: stream ports, input register, result register.
// ----------------------------------------------------------------------------
module aabb_circle_overlap_test #(
    parameter int COORD_BITS = aabbco_pkg::COORD_BITS_DEF,
    localparam int FIELD_W   = 10 * COORD_BITS - 6,
    localparam int DATA_W    = ((FIELD_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x_a, pos_y_a, box_w_a, box_h_a, rad_a,
    // pos_x_b, pos_y_b, box_w_b, box_h_b, rad_b, zero fill
    input  logic [DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]        s_axis_tuser,     // kind_a, kind_b
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata      // overlap, zero fill
);
    import aabbco_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [FIELD_W-1:0] in_fields_reg;
    logic [1:0]         in_kinds_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               overlap_reg;
    logic               overlap_calc;
    logic               advance;
    logic               take_in;

    // the result register frees up when empty or being read this cycle
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
    end

    aabbco_calc #(.COORD_BITS(COORD_BITS)) u_calc (
        .kinds   (in_kinds_reg),
        .fields  (in_fields_reg),
        .overlap (overlap_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_fields_reg <= s_axis_tdata[FIELD_W-1:0];
            in_kinds_reg  <= s_axis_tuser;
        end
        if (advance && in_valid_reg)
            overlap_reg <= overlap_calc;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, overlap_reg};

    // an item waiting in the input register moves on once the result slot frees
    a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("input item did not reach the result register");

    // a stalled input item keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_fields_reg)
                                     && $stable(in_kinds_reg))
        else $error("stalled input item lost or changed");

    // two circles with the same centre always overlap
    a_same_centre: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance
        && (pair_kind_t'({in_kinds_reg[0], in_kinds_reg[1]}) == PAIR_CIRC_CIRC)
        && (in_fields_reg[COORD_BITS-1:0] == in_fields_reg[6*COORD_BITS-4:5*COORD_BITS-3])
        && (in_fields_reg[2*COORD_BITS-1:COORD_BITS]
            == in_fields_reg[7*COORD_BITS-4:6*COORD_BITS-3])
        |=> overlap_reg)
        else $error("concentric circles reported apart");

endmodule

// File: src/aabbco_axis.sv
// ----------------------------------------------------------------------------
// aabbco_axis
// One axis of the overlap test: box separation flag and the unsigned
// distance that gets squared for the circle cases.
// ----------------------------------------------------------------------------
module aabbco_axis #(
    parameter int COORD_BITS = 16
) (
    input  aabbco_pkg::pair_kind_t  mode,
    input  logic [COORD_BITS-1:0]   pos_a,
    input  logic [COORD_BITS-1:0]   pos_b,
    input  logic [COORD_BITS-2:0]   size_a,
    input  logic [COORD_BITS-2:0]   size_b,
    output logic                    sep,
    output logic [COORD_BITS-1:0]   gap_dist
);
    import aabbco_pkg::*;

    localparam int W = COORD_BITS + 2;

    logic signed [W-1:0] pa;
    logic signed [W-1:0] pb;
    logic signed [W-1:0] sa;
    logic signed [W-1:0] sb;
    logic signed [W-1:0] t;
    logic signed [W-1:0] neg_t;
    logic signed [W-1:0] box_lo;
    logic signed [W-1:0] box_size;
    logic signed [W-1:0] box_hi;
    logic signed [W-1:0] ctr;
    logic signed [W-1:0] gap;

    assign pa    = {{2{pos_a[COORD_BITS-1]}}, pos_a};
    assign pb    = {{2{pos_b[COORD_BITS-1]}}, pos_b};
    assign sa    = {3'b000, size_a};
    assign sb    = {3'b000, size_b};
    assign t     = pa - pb;
    assign neg_t = pb - pa;

    // touching edges count as overlap, so only a strict excess separates
    assign sep = (t > sb) || (neg_t > sa);

    always_comb
    begin
        if (mode == PAIR_BOX_CIRC)
        begin
            box_lo   = pa;
            box_size = sa;
            ctr      = pb;
        end
        else
        begin
            box_lo   = pb;
            box_size = sb;
            ctr      = pa;
        end
        box_hi = box_lo + box_size;
        priority if (ctr < box_lo)
            gap = box_lo - ctr;
        else if (ctr > box_hi)
            gap = ctr - box_hi;
        else
            gap = '0;
    end

    // every distance magnitude stays below 2^COORD_BITS
    always_comb
    begin
        unique case (mode)
            PAIR_BOX_BOX:   gap_dist = '0;
            PAIR_BOX_CIRC,
            PAIR_CIRC_BOX:  gap_dist = gap[COORD_BITS-1:0];
            PAIR_CIRC_CIRC: gap_dist = t[W-1] ? neg_t[COORD_BITS-1:0] : t[COORD_BITS-1:0];
            default:        gap_dist = '0;
        endcase
    end

endmodule

// File: src/aabbco_eval.sv
// ----------------------------------------------------------------------------
// aabbco_eval
// Squares the axis distances and the radius term, compares, and picks
// the answer for the shape pairing.
// ----------------------------------------------------------------------------
module aabbco_eval #(
    parameter int COORD_BITS = 16
) (
    input  aabbco_pkg::pair_kind_t  mode,
    input  logic                    sep_x,
    input  logic                    sep_y,
    input  logic [COORD_BITS-1:0]   dist_x,
    input  logic [COORD_BITS-1:0]   dist_y,
    input  logic [COORD_BITS-2:0]   rad_a,
    input  logic [COORD_BITS-2:0]   rad_b,
    output logic                    overlap
);
    import aabbco_pkg::*;

    logic [COORD_BITS-1:0]   rad_term;
    logic [2*COORD_BITS-1:0] sq_x;
    logic [2*COORD_BITS-1:0] sq_y;
    logic [2*COORD_BITS-1:0] sq_r;
    logic [2*COORD_BITS:0]   dist_sum;

    always_comb
    begin
        unique case (mode)
            PAIR_BOX_BOX:   rad_term = '0;
            PAIR_BOX_CIRC:  rad_term = {1'b0, rad_b};
            PAIR_CIRC_BOX:  rad_term = {1'b0, rad_a};
            PAIR_CIRC_CIRC: rad_term = {1'b0, rad_a} + {1'b0, rad_b};
            default:        rad_term = '0;
        endcase
    end

    assign sq_x     = dist_x * dist_x;
    assign sq_y     = dist_y * dist_y;
    assign sq_r     = rad_term * rad_term;
    assign dist_sum = {1'b0, sq_x} + {1'b0, sq_y};

    assign overlap = (mode == PAIR_BOX_BOX) ? !(sep_x || sep_y)
                                            : (dist_sum <= {1'b0, sq_r});

endmodule

// File: src/aabbco_calc.sv
// ----------------------------------------------------------------------------
// aabbco_calc
// Combinational overlap test between the input and result registers:
// unpacks one shape pair, runs both axes and the final compare.
// ----------------------------------------------------------------------------
module aabbco_calc #(
    parameter int COORD_BITS = 16
) (
    input  logic [1:0]              kinds,      // kind_a, kind_b
    input  logic [10*COORD_BITS-7:0] fields,    // tdata field layout, no padding
    output logic                    overlap
);
    import aabbco_pkg::*;

    localparam int C = COORD_BITS;

    pair_kind_t            mode;
    logic                  sep_x;
    logic                  sep_y;
    logic [C-1:0]          dist_x;
    logic [C-1:0]          dist_y;

    assign mode = pair_kind_t'({kinds[0], kinds[1]});

    aabbco_axis #(.COORD_BITS(C)) u_axis_x (
        .mode     (mode),
        .pos_a    (fields[C-1:0]),
        .pos_b    (fields[6*C-4:5*C-3]),
        .size_a   (fields[3*C-2:2*C]),
        .size_b   (fields[8*C-5:7*C-3]),
        .sep      (sep_x),
        .gap_dist (dist_x)
    );

    aabbco_axis #(.COORD_BITS(C)) u_axis_y (
        .mode     (mode),
        .pos_a    (fields[2*C-1:C]),
        .pos_b    (fields[7*C-4:6*C-3]),
        .size_a   (fields[4*C-3:3*C-1]),
        .size_b   (fields[9*C-6:8*C-4]),
        .sep      (sep_y),
        .gap_dist (dist_y)
    );

    aabbco_eval #(.COORD_BITS(C)) u_eval (
        .mode    (mode),
        .sep_x   (sep_x),
        .sep_y   (sep_y),
        .dist_x  (dist_x),
        .dist_y  (dist_y),
        .rad_a   (fields[5*C-4:4*C-2]),
        .rad_b   (fields[10*C-7:9*C-5]),
        .overlap (overlap)
    );

endmodule

// File: sim/aabb_circle_overlap_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_circle_overlap_test_tb
// Self-checking bench for the box / circle overlap test. Shape pairs are
// streamed in with random bursts and gaps while the result side stalls on its
// own pattern. Each accepted pair is scored by an independent integer model of
// the three overlap cases, and every returned flag is compared in order.
// ----------------------------------------------------------------------------
module aabb_circle_overlap_test_tb;

    import aabbco_pkg::*;

    localparam int  COORD_W    = COORD_BITS_DEF;
    localparam int  DATA_W     = 160;
    localparam int  NUM_RANDOM = 2000;
    localparam int  HOLD_LEN   = 400;
    localparam bit  KIND_BOX    = 1'b0;
    localparam bit  KIND_CIRCLE = 1'b1;

    typedef struct packed {
        logic                      circ;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [COORD_W-2:0] w;
        logic        [COORD_W-2:0] h;
        logic        [COORD_W-2:0] r;
    } shape_t;

    typedef struct packed {
        shape_t a;
        shape_t b;
    } pair_t;

    // ------------------------------------------------------------------------
    // expected overlap flags, computed when a pair is accepted
    // ------------------------------------------------------------------------
    class overlap_scoreboard;
        bit flags_due[$];
        int errors;

        function longint coord(logic signed [COORD_W-1:0] v);
            return v;
        endfunction

        function longint ext(logic [COORD_W-2:0] v);
            return v;
        endfunction

        function longint sq(longint v);
            return v * v;
        endfunction

        // squared distance from c to the span [lo, lo + len] on one axis
        function longint gap_sq(longint c, longint lo, longint len);
            longint hi;
            hi = lo + len;
            if (c < lo)
                return sq(lo - c);
            if (c > hi)
                return sq(hi - c);
            return 0;
        endfunction

        function bit box_box(shape_t p, shape_t q);
            longint t;
            t = coord(p.x) - coord(q.x);
            if (t > ext(q.w) || -t > ext(p.w))
                return 1'b0;
            t = coord(p.y) - coord(q.y);
            if (t > ext(q.h) || -t > ext(p.h))
                return 1'b0;
            return 1'b1;
        endfunction

        function bit box_circle(shape_t bx, shape_t c);
            longint dist_sq;
            dist_sq = gap_sq(coord(c.x), coord(bx.x), ext(bx.w))
                    + gap_sq(coord(c.y), coord(bx.y), ext(bx.h));
            return dist_sq <= sq(ext(c.r));
        endfunction

        function bit circle_circle(shape_t p, shape_t q);
            longint dist_sq;
            dist_sq = sq(coord(p.x) - coord(q.x)) + sq(coord(p.y) - coord(q.y));
            return dist_sq <= sq(ext(p.r) + ext(q.r));
        endfunction

        function bit shapes_overlap(pair_t p);
            pair_kind_t kind;
            kind = pair_kind_t'({p.a.circ, p.b.circ});
            unique case (kind)
                PAIR_BOX_BOX:   return box_box(p.a, p.b);
                PAIR_BOX_CIRC:  return box_circle(p.a, p.b);
                PAIR_CIRC_BOX:  return box_circle(p.b, p.a);
                default:        return circle_circle(p.a, p.b);
            endcase
        endfunction

        function void note_pair(pair_t p);
            flags_due.push_back(shapes_overlap(p));
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (flags_due.size() == 0)
            begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, got);
                errors++;
            end
            else
            begin
                want = {7'b0, flags_due.pop_front()};
                if (got !== want)
                begin
                    $display("%0t: overlap mismatch, expected %h, actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return flags_due.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;

    overlap_scoreboard flag_book;
    bit                hold_req = 1'b0;

    always #6 clk = ~clk;

    aabb_circle_overlap_test i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic shape_t mk_shape(bit circ, int x, int y, int w, int h, int r);
        shape_t s;
        s.circ = circ;
        s.x    = x[COORD_W-1:0];
        s.y    = y[COORD_W-1:0];
        s.w    = w[COORD_W-2:0];
        s.h    = h[COORD_W-2:0];
        s.r    = r[COORD_W-2:0];
        return s;
    endfunction

    // shape placed within spread / 2 of (cx, cy), sizes up to spread
    function automatic shape_t near_shape(int cx, int cy, int spread);
        int dx;
        int dy;
        int w;
        int h;
        int r;
        dx = int'($urandom_range(spread)) - spread / 2;
        dy = int'($urandom_range(spread)) - spread / 2;
        w  = int'($urandom_range(spread));
        h  = int'($urandom_range(spread));
        r  = int'($urandom_range(spread));
        return mk_shape(1'($urandom_range(1)), cx + dx, cy + dy, w, h, r);
    endfunction

    function automatic pair_t random_pair();
        pair_t             p;
        logic [DATA_W-1:0] raw;
        int                spread;
        int                cx;
        int                cy;
        if ($urandom_range(3) == 0)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            p   = raw[$bits(pair_t)-1:0];
        end
        else
        begin
            spread = 1 << $urandom_range(3, 15);
            cx     = $urandom;
            cy     = $urandom;
            p.a    = near_shape(cx, cy, spread);
            p.b    = near_shape(cx, cy, spread);
        end
        return p;
    endfunction

    // holds the pair on the bus until the transfer completes
    task automatic send_pair(shape_t a, shape_t b);
        pair_t p;
        p.a = a;
        p.b = b;
        s_axis_tdata  <= {6'b0, b.r, b.h, b.w, b.y, b.x, a.r, a.h, a.w, a.y, a.x};
        s_axis_tuser  <= {b.circ, a.circ};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        flag_book.note_pair(p);
    endtask

    task automatic idle_input(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        idle_input(1);
        while (flag_book.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random stall pattern, plus one long hold on request
    initial
    begin
        int hold_left;
        int mode_left;
        int ready_pct;
        hold_left = 0;
        mode_left = 0;
        ready_pct = 100;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                flag_book.check_result(m_axis_tdata);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(50, 300);
                    case ($urandom_range(3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 75;
                        2:       ready_pct = 50;
                        default: ready_pct = 15;
                    endcase
                end
                mode_left--;
                m_axis_tready <= ($urandom_range(99) < ready_pct);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("aabb_circle_overlap_test verification failed");
        $finish;
    end

    initial
    begin
        pair_t p;
        int    sent;
        int    burst;
        int    gap;
        flag_book = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // boxes: edge and corner contact, one step apart, extremes
        send_pair(mk_shape(KIND_BOX, 0, 0, 16, 16, 0), mk_shape(KIND_BOX, 16, 0, 16, 16, 0));
        send_pair(mk_shape(KIND_BOX, 0, 0, 16, 16, 0), mk_shape(KIND_BOX, 17, 0, 16, 16, 0));
        send_pair(mk_shape(KIND_BOX, 0, 0, 16, 16, 0),
                  mk_shape(KIND_BOX, -16, -16, 16, 16, 0));
        send_pair(mk_shape(KIND_BOX, 0, 0, 16, 16, 0), mk_shape(KIND_BOX, -17, 0, 16, 16, 0));
        send_pair(mk_shape(KIND_BOX, 0, 0, 16, 16, 0), mk_shape(KIND_BOX, 0, 16, 16, 16, 0));
        send_pair(mk_shape(KIND_BOX, 0, 0, 16, 16, 0), mk_shape(KIND_BOX, 0, 17, 16, 16, 0));
        send_pair(mk_shape(KIND_BOX, -32768, -32768, 32767, 32767, 0),
                  mk_shape(KIND_BOX, 32767, 32767, 32767, 32767, 0));
        send_pair(mk_shape(KIND_BOX, -32768, -32768, 32767, 32767, 0),
                  mk_shape(KIND_BOX, -1, -1, 0, 0, 0));
        send_pair(mk_shape(KIND_BOX, 100, -100, 0, 0, 32767),
                  mk_shape(KIND_BOX, 100, -100, 0, 0, 32767));
        send_pair(mk_shape(KIND_BOX, -1, -1, 32767, 32767, 32767),
                  mk_shape(KIND_BOX, -1, -1, 32767, 32767, 32767));

        // box and circle: below and above the edges, inside, far apart
        send_pair(mk_shape(KIND_BOX, 0, 0, 16, 16, 0),
                  mk_shape(KIND_CIRCLE, -48, -64, 0, 0, 80));
        send_pair(mk_shape(KIND_BOX, 0, 0, 16, 16, 0),
                  mk_shape(KIND_CIRCLE, -48, -64, 0, 0, 79));
        send_pair(mk_shape(KIND_BOX, 0, 0, 16, 16, 0),
                  mk_shape(KIND_CIRCLE, 64, 80, 0, 0, 80));
        send_pair(mk_shape(KIND_CIRCLE, 8, 8, 0, 0, 0), mk_shape(KIND_BOX, 0, 0, 16, 16, 0));
        send_pair(mk_shape(KIND_CIRCLE, 8, -20, 0, 0, 20),
                  mk_shape(KIND_BOX, 0, 0, 16, 16, 0));
        send_pair(mk_shape(KIND_CIRCLE, 8, -20, 0, 0, 19),
                  mk_shape(KIND_BOX, 0, 0, 16, 16, 0));
        send_pair(mk_shape(KIND_CIRCLE, 32767, 32767, 32767, 32767, 32767),
                  mk_shape(KIND_BOX, -32768, -32768, 32767, 32767, 32767));

        // circles: touching, one step short, extremes
        send_pair(mk_shape(KIND_CIRCLE, 0, 0, 0, 0, 30), mk_shape(KIND_CIRCLE, 48, 64, 0, 0, 50));
        send_pair(mk_shape(KIND_CIRCLE, 0, 0, 0, 0, 30), mk_shape(KIND_CIRCLE, 48, 64, 0, 0, 49));
        send_pair(mk_shape(KIND_CIRCLE, -32768, 0, 0, 0, 32767),
                  mk_shape(KIND_CIRCLE, 32767, 0, 0, 0, 32767));
        send_pair(mk_shape(KIND_CIRCLE, -32768, 0, 0, 0, 32767),
                  mk_shape(KIND_CIRCLE, 32766, 0, 0, 0, 32767));
        send_pair(mk_shape(KIND_CIRCLE, -32768, -32768, 0, 0, 32767),
                  mk_shape(KIND_CIRCLE, 32767, 32767, 0, 0, 32767));
        send_pair(mk_shape(KIND_CIRCLE, -1, -1, 32767, 32767, 0),
                  mk_shape(KIND_CIRCLE, -1, -1, 32767, 32767, 0));
        drain_results();

        // long result-side hold while pairs keep coming back to back
        hold_req = 1'b1;
        for (int i = 0; i < 80; i++)
        begin
            p = random_pair();
            send_pair(p.a, p.b);
        end
        drain_results();

        sent = 80;
        while (sent < NUM_RANDOM)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst; i++)
            begin
                p = random_pair();
                send_pair(p.a, p.b);
                sent++;
            end
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                idle_input(gap);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (flag_book.errors == 0)
            $display("aabb_circle_overlap_test verification clean");
        else
            $display("aabb_circle_overlap_test verification failed");
        $finish;
    end

endmodule
